/* hw/rtl/hmet_pkg.sv */
// Package for the hand motion expression tracker.
// Holds the shared constants, payload and control types and the coefficient clamp.
// Depends on nothing; every other RTL file imports it.
package hmet_pkg;

   // Number of magnitudes averaged per hand.
   localparam int WINDOW_SIZE = 8;

   localparam int VEL_W   = 16;
   localparam int MAG_W   = 17;
   localparam int SUM_W   = MAG_W + $clog2(WINDOW_SIZE + 1);
   localparam int SPD_W   = 24;
   localparam int COEF_W  = 17;
   localparam int SCALE_W = 24;
   localparam int Q16_FRAC = 16;

   localparam logic [COEF_W-1:0] Q16_ONE = COEF_W'(65536);
   localparam logic [SPD_W-1:0]  SPD_MAX = '1;

   // Configuration register map.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_SCALE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_DECAY  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_SPEED = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_PEAK  = 3'd4;

   localparam logic [SCALE_W-1:0] RST_SPEED_SCALE = SCALE_W'(7600);
   localparam logic [COEF_W-1:0]  RST_SMOOTH_GAIN = COEF_W'(3002);
   localparam logic [COEF_W-1:0]  RST_PEAK_DECAY  = COEF_W'(63242);
   localparam logic [COEF_W-1:0]  RST_BLEND_SPEED = COEF_W'(12698);
   localparam logic [COEF_W-1:0]  RST_BLEND_PEAK  = COEF_W'(53965);

   typedef struct packed {
      logic signed [VEL_W-1:0] left_vel_x;
      logic signed [VEL_W-1:0] left_vel_y;
      logic signed [VEL_W-1:0] left_vel_z;
      logic signed [VEL_W-1:0] right_vel_x;
      logic signed [VEL_W-1:0] right_vel_y;
      logic signed [VEL_W-1:0] right_vel_z;
   } req_type;

   typedef struct packed {
      logic [SPD_W-1:0]  left_speed;
      logic [SPD_W-1:0]  left_smooth;
      logic [SPD_W-1:0]  left_peak;
      logic [COEF_W-1:0] left_expression;
      logic [SPD_W-1:0]  right_speed;
      logic [SPD_W-1:0]  right_smooth;
      logic [SPD_W-1:0]  right_peak;
      logic [COEF_W-1:0] right_expression;
   } rsp_type;

   // Coefficients as the per-hand datapath sees them (weights already clamped to one).
   typedef struct packed {
      logic [SCALE_W-1:0] speed_scale;
      logic [COEF_W-1:0]  smooth_gain;
      logic [COEF_W-1:0]  peak_decay;
      logic [COEF_W-1:0]  blend_speed;
      logic [COEF_W-1:0]  blend_peak;
   } coef_type;

   typedef struct packed {
      logic start;
      logic take;
   } hand_cmd_type;

   typedef struct packed {
      logic [SPD_W-1:0]  speed;
      logic [SPD_W-1:0]  smooth;
      logic [SPD_W-1:0]  peak;
      logic [COEF_W-1:0] expression;
   } hand_res_type;

   // A Q1.16 weight above one is used as one.
   function automatic logic [COEF_W-1:0] coef_sat(input logic [COEF_W-1:0] c);
      logic [COEF_W-1:0] r;
      r = (c > Q16_ONE) ? Q16_ONE : c;
      return r;
   endfunction

endpackage

/* hw/rtl/hmet_req_if.sv */
// Input channel of the hand motion expression tracker: valid, ready and one frame.
// Depends on hmet_pkg for the payload type.
interface hmet_req_if;
   logic             valid;
   logic             ready;
   hmet_pkg::req_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

/* hw/rtl/hmet_rsp_if.sv */
// Result channel of the hand motion expression tracker: valid, ready and one result.
// Depends on hmet_pkg for the payload type.
interface hmet_rsp_if;
   logic             valid;
   logic             ready;
   hmet_pkg::rsp_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

/* hw/rtl/hand_motion_expression_tracker.sv */
// Top level of the hand motion expression tracker: handshake, configuration
// registers, result register and one serial datapath per hand.
// Depends on hmet_pkg, hmet_req_if, hmet_rsp_if and hmet_hand.
//
// A result moves into the output register once the datapath is done and the
// output register is free. The datapath runs 16 sum-of-squares steps, 16 root
// steps, 21 steps for the speed product, 17 for each of the four weighted
// products and six further stages. A new item is accepted once the previous
// result moves into the output register; a window size that is not a power of
// two adds a long division, one quotient bit per cycle (SUM_W + 16 of them).
// Reset is synchronous: coefficients return to defaults, histories, window sums,
// smoothed speeds and peaks clear to zero at once, with no clearing pass.
module hand_motion_expression_tracker import hmet_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   hmet_req_if.sink              req_chan,
   hmet_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers; the user must write them only while the block is idle (not enforced here).
   logic [SCALE_W-1:0] speed_scale_ff;
   logic [COEF_W-1:0]  smooth_gain_ff;
   logic [COEF_W-1:0]  peak_decay_ff;
   logic [COEF_W-1:0]  blend_speed_ff;
   logic [COEF_W-1:0]  blend_peak_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_scale_ff <= RST_SPEED_SCALE;
         smooth_gain_ff <= RST_SMOOTH_GAIN;
         peak_decay_ff  <= RST_PEAK_DECAY;
         blend_speed_ff <= RST_BLEND_SPEED;
         blend_peak_ff  <= RST_BLEND_PEAK;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SPEED_SCALE: speed_scale_ff <= csr_wdata[SCALE_W-1:0];
            CSR_SMOOTH_GAIN: smooth_gain_ff <= csr_wdata[COEF_W-1:0];
            CSR_PEAK_DECAY:  peak_decay_ff  <= csr_wdata[COEF_W-1:0];
            CSR_BLEND_SPEED: blend_speed_ff <= csr_wdata[COEF_W-1:0];
            CSR_BLEND_PEAK:  blend_peak_ff  <= csr_wdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   // Weights above one act as one; the datapath only ever sees clamped weights.
   coef_type coef;
   assign coef.speed_scale = speed_scale_ff;
   assign coef.smooth_gain = coef_sat(smooth_gain_ff);
   assign coef.peak_decay  = coef_sat(peak_decay_ff);
   assign coef.blend_speed = coef_sat(blend_speed_ff);
   assign coef.blend_peak  = coef_sat(blend_peak_ff);

   // Control: busy_ff covers an item from acceptance until its result moves
   // into the output register. The output register frees the datapath, so a
   // new item is taken while the previous result still waits downstream.
   logic         busy_ff, busy_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff;
   logic         accept;
   logic         left_done, right_done;
   logic         take;
   hand_cmd_type cmd;
   hand_res_type left_res, right_res;

   assign req_chan.ready = !busy_ff;
   assign accept         = req_chan.valid && !busy_ff;

   // Both hands run the same fixed schedule, so they finish together.
   assign take      = left_done && right_done && (!rsp_valid_ff || rsp_chan.ready);
   assign cmd.start = accept;
   assign cmd.take  = take;

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (take) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff.left_speed       <= left_res.speed;
         rsp_data_ff.left_smooth      <= left_res.smooth;
         rsp_data_ff.left_peak        <= left_res.peak;
         rsp_data_ff.left_expression  <= left_res.expression;
         rsp_data_ff.right_speed      <= right_res.speed;
         rsp_data_ff.right_smooth     <= right_res.smooth;
         rsp_data_ff.right_peak       <= right_res.peak;
         rsp_data_ff.right_expression <= right_res.expression;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // The hands take the velocity components straight from the channel on the
   // accepting edge and keep their own copies from then on.
   hmet_hand u_left (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .coef  (coef),
      .vel_x (req_chan.payload.left_vel_x),
      .vel_y (req_chan.payload.left_vel_y),
      .vel_z (req_chan.payload.left_vel_z),
      .done  (left_done),
      .res   (left_res)
   );

   hmet_hand u_right (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .coef  (coef),
      .vel_x (req_chan.payload.right_vel_x),
      .vel_y (req_chan.payload.right_vel_y),
      .vel_z (req_chan.payload.right_vel_z),
      .done  (right_done),
      .res   (right_res)
   );

   a_hands_in_step: assert property (@(posedge clock) disable iff (reset)
      left_done == right_done)
      else $error("hand datapaths out of step");

   a_done_only_busy: assert property (@(posedge clock) disable iff (reset)
      left_done |-> busy_ff)
      else $error("result finished with no item in flight");

   a_take_fills_output: assert property (@(posedge clock) disable iff (reset)
      take |=> (rsp_valid_ff && !busy_ff))
      else $error("finished item did not reach the output register");

endmodule

/* hw/rtl/hmet_hand.sv */
// Per-hand datapath: bit-serial sum of squares, digit-by-digit square root,
// magnitude window, bit-serial speed product divided by the window size, and weighted blends.
// Depends on hmet_pkg.
module hmet_hand import hmet_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  hand_cmd_type            cmd,
   input  coef_type                coef,
   input  logic signed [VEL_W-1:0] vel_x,
   input  logic signed [VEL_W-1:0] vel_y,
   input  logic signed [VEL_W-1:0] vel_z,
   output logic                    done,
   output hand_res_type            res
);

   localparam int MUL_W   = (SUM_W > COEF_W) ? SUM_W : COEF_W;
   localparam int OPD_W   = SCALE_W;
   localparam int TERM_W  = OPD_W + 2;
   localparam int ACC_W   = SUM_W + SCALE_W;
   localparam int SQ_W    = 2 * VEL_W;
   localparam int ROOT_W  = VEL_W;
   localparam int REM_W   = ROOT_W + 2;
   localparam int DIV_SHIFT = 8;
   localparam int QUO_W   = ACC_W - DIV_SHIFT;
   localparam int CNT_W   = $clog2(ACC_W + 1);
   localparam int LOG2W   = $clog2(WINDOW_SIZE);
   localparam bit WIN_POW2 = ((1 << LOG2W) == WINDOW_SIZE);
   localparam int DREM_W  = $clog2(WINDOW_SIZE + 1);

   localparam logic [TERM_W-1:0] ROUND_TERM = TERM_W'(1) << (Q16_FRAC - 1);
   localparam logic [DREM_W:0]   WIN_DIV    = (DREM_W + 1)'(WINDOW_SIZE);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SQ   = 4'd1;
   localparam logic [3:0] S_ROOT = 4'd2;
   localparam logic [3:0] S_WIN  = 4'd3;
   localparam logic [3:0] S_MSPD = 4'd4;
   localparam logic [3:0] S_DIV  = 4'd5;
   localparam logic [3:0] S_SPD  = 4'd6;
   localparam logic [3:0] S_MSM  = 4'd7;
   localparam logic [3:0] S_SMF  = 4'd8;
   localparam logic [3:0] S_MPK  = 4'd9;
   localparam logic [3:0] S_PKF  = 4'd10;
   localparam logic [3:0] S_ME1  = 4'd11;
   localparam logic [3:0] S_E1F  = 4'd12;
   localparam logic [3:0] S_MEX  = 4'd13;
   localparam logic [3:0] S_EXF  = 4'd14;
   localparam logic [3:0] S_DONE = 4'd15;

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MUL_W-1:0]  m0_ff, m0_in, m1_ff, m1_in, m2_ff, m2_in;
   logic [OPD_W-1:0]  a0_ff, a0_in, a1_ff, a1_in, a2_ff, a2_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DREM_W-1:0] drem_ff, drem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [MAG_W-1:0]  hist_ff [WINDOW_SIZE];
   logic [MAG_W-1:0]  hist_in [WINDOW_SIZE];
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SPD_W-1:0]  speed_ff, speed_in;
   logic [SPD_W-1:0]  sm_ff, sm_in;
   logic [SPD_W-1:0]  pk_ff, pk_in;
   logic [COEF_W-1:0] ex_ff, ex_in;

   logic [VEL_W-1:0]  abs_x, abs_y, abs_z;
   logic              last_step, round_en;
   logic [TERM_W-1:0] term;
   logic [ACC_W-1:0]  mac_next;
   logic [REM_W+1:0]  rem_try, root_trial;
   logic              root_ge;
   logic [DREM_W:0]   div_try;
   logic              div_ge;
   logic [ACC_W-1:0]  spd_wide;
   logic [SPD_W-1:0]  speed_new;
   logic [SPD_W-1:0]  blend_res;
   logic [MAG_W-1:0]  mag;
   logic [SUM_W-1:0]  sum_new;

   assign abs_x = vel_x[VEL_W-1] ? VEL_W'(~vel_x + 1'b1) : VEL_W'(vel_x);
   assign abs_y = vel_y[VEL_W-1] ? VEL_W'(~vel_y + 1'b1) : VEL_W'(vel_y);
   assign abs_z = vel_z[VEL_W-1] ? VEL_W'(~vel_z + 1'b1) : VEL_W'(vel_z);

   // Multiply-accumulate step, most significant multiplier bit first.
   assign last_step = (cnt_ff == CNT_W'(1));
   assign round_en  = last_step && ((state_ff == S_MSM) || (state_ff == S_MPK) ||
                                    (state_ff == S_ME1) || (state_ff == S_MEX));
   assign term = (m0_ff[MUL_W-1] ? TERM_W'(a0_ff) : '0) +
                 (m1_ff[MUL_W-1] ? TERM_W'(a1_ff) : '0) +
                 (m2_ff[MUL_W-1] ? TERM_W'(a2_ff) : '0) +
                 (round_en ? ROUND_TERM : '0);
   assign mac_next  = {acc_ff[ACC_W-2:0], 1'b0} + ACC_W'(term);
   assign blend_res = acc_ff[Q16_FRAC +: SPD_W];

   // Square root: two radicand bits per cycle.
   assign rem_try    = {rem_ff, acc_ff[SQ_W-1 -: 2]};
   assign root_trial = (REM_W + 2)'({root_ff, 2'b01});
   assign root_ge    = (rem_try >= root_trial);

   // Long division by the window size, one quotient bit per cycle.
   assign div_try = {drem_ff, acc_ff[ACC_W-1]};
   assign div_ge  = (div_try >= WIN_DIV);

   assign spd_wide  = WIN_POW2 ? (acc_ff >> (DIV_SHIFT + LOG2W)) : ACC_W'(quo_ff);
   assign speed_new = (|(spd_wide >> SPD_W)) ? SPD_MAX : spd_wide[SPD_W-1:0];

   assign mag     = MAG_W'(root_ff);
   assign sum_new = sum_ff - SUM_W'(hist_ff[WINDOW_SIZE-1]) + SUM_W'(mag);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      m0_in    = m0_ff;
      m1_in    = m1_ff;
      m2_in    = m2_ff;
      a0_in    = a0_ff;
      a1_in    = a1_ff;
      a2_in    = a2_ff;
      acc_in   = acc_ff;
      root_in  = root_ff;
      rem_in   = rem_ff;
      drem_in  = drem_ff;
      quo_in   = quo_ff;
      hist_in  = hist_ff;
      sum_in   = sum_ff;
      speed_in = speed_ff;
      sm_in    = sm_ff;
      pk_in    = pk_ff;
      ex_in    = ex_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               m0_in    = MUL_W'(abs_x) << (MUL_W - VEL_W);
               m1_in    = MUL_W'(abs_y) << (MUL_W - VEL_W);
               m2_in    = MUL_W'(abs_z) << (MUL_W - VEL_W);
               a0_in    = OPD_W'(abs_x);
               a1_in    = OPD_W'(abs_y);
               a2_in    = OPD_W'(abs_z);
               acc_in   = '0;
               cnt_in   = CNT_W'(VEL_W);
               state_in = S_SQ;
            end
         end
         S_SQ, S_MSPD, S_MSM, S_MPK, S_ME1, S_MEX: begin
            acc_in = mac_next;
            m0_in  = m0_ff << 1;
            m1_in  = m1_ff << 1;
            m2_in  = m2_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (last_step) begin
               case (state_ff)
                  S_SQ: begin
                     root_in  = '0;
                     rem_in   = '0;
                     cnt_in   = CNT_W'(ROOT_W);
                     state_in = S_ROOT;
                  end
                  S_MSPD: begin
                     drem_in  = '0;
                     quo_in   = '0;
                     cnt_in   = CNT_W'(QUO_W);
                     state_in = WIN_POW2 ? S_SPD : S_DIV;
                  end
                  S_MSM:   state_in = S_SMF;
                  S_MPK:   state_in = S_PKF;
                  S_ME1:   state_in = S_E1F;
                  default: state_in = S_EXF;
               endcase
            end
         end
         S_ROOT: begin
            acc_in  = acc_ff << 2;
            rem_in  = root_ge ? REM_W'(rem_try - root_trial) : REM_W'(rem_try);
            root_in = {root_ff[ROOT_W-2:0], root_ge};
            cnt_in  = cnt_ff - 1'b1;
            if (last_step) begin
               state_in = S_WIN;
            end
         end
         S_WIN: begin
            for (int i = WINDOW_SIZE - 1; i > 0; i--) begin
               hist_in[i] = hist_ff[i-1];
            end
            hist_in[0] = mag;
            sum_in     = sum_new;
            m0_in      = MUL_W'(sum_new) << (MUL_W - SUM_W);
            m1_in      = '0;
            m2_in      = '0;
            a0_in      = coef.speed_scale;
            acc_in     = '0;
            cnt_in     = CNT_W'(SUM_W);
            state_in   = S_MSPD;
         end
         S_DIV: begin
            acc_in  = acc_ff << 1;
            drem_in = div_ge ? DREM_W'(div_try - WIN_DIV) : DREM_W'(div_try);
            quo_in  = {quo_ff[QUO_W-2:0], div_ge};
            cnt_in  = cnt_ff - 1'b1;
            if (last_step) begin
               state_in = S_SPD;
            end
         end
         S_SPD: begin
            // Smoothing as a blend: g*speed + (1-g)*old equals old + g*(speed-old).
            speed_in = speed_new;
            m0_in    = MUL_W'(coef.smooth_gain) << (MUL_W - COEF_W);
            m1_in    = MUL_W'(Q16_ONE - coef.smooth_gain) << (MUL_W - COEF_W);
            m2_in    = '0;
            a0_in    = speed_new;
            a1_in    = sm_ff;
            acc_in   = '0;
            cnt_in   = CNT_W'(COEF_W);
            state_in = S_MSM;
         end
         S_SMF: begin
            sm_in    = blend_res;
            m0_in    = MUL_W'(coef.peak_decay) << (MUL_W - COEF_W);
            m1_in    = '0;
            a0_in    = pk_ff;
            acc_in   = '0;
            cnt_in   = CNT_W'(COEF_W);
            state_in = S_MPK;
         end
         S_PKF: begin
            pk_in    = (speed_ff > blend_res) ? speed_ff : blend_res;
            m0_in    = MUL_W'(coef.blend_speed) << (MUL_W - COEF_W);
            m1_in    = MUL_W'(Q16_ONE - coef.blend_speed) << (MUL_W - COEF_W);
            a0_in    = speed_ff;
            a1_in    = sm_ff;
            acc_in   = '0;
            cnt_in   = CNT_W'(COEF_W);
            state_in = S_ME1;
         end
         S_E1F: begin
            m0_in    = MUL_W'(coef.blend_peak) << (MUL_W - COEF_W);
            m1_in    = MUL_W'(Q16_ONE - coef.blend_peak) << (MUL_W - COEF_W);
            a0_in    = blend_res;
            a1_in    = pk_ff;
            acc_in   = '0;
            cnt_in   = CNT_W'(COEF_W);
            state_in = S_MEX;
         end
         S_EXF: begin
            ex_in    = (blend_res > SPD_W'(Q16_ONE)) ? Q16_ONE : blend_res[COEF_W-1:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (cmd.take) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < WINDOW_SIZE; i++) begin
            hist_ff[i] <= '0;
         end
         sum_ff <= '0;
         sm_ff  <= '0;
         pk_ff  <= '0;
      end else begin
         state_ff <= state_in;
         hist_ff  <= hist_in;
         sum_ff   <= sum_in;
         sm_ff    <= sm_in;
         pk_ff    <= pk_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      m0_ff    <= m0_in;
      m1_ff    <= m1_in;
      m2_ff    <= m2_in;
      a0_ff    <= a0_in;
      a1_ff    <= a1_in;
      a2_ff    <= a2_in;
      acc_ff   <= acc_in;
      root_ff  <= root_in;
      rem_ff   <= rem_in;
      drem_ff  <= drem_in;
      quo_ff   <= quo_in;
      speed_ff <= speed_in;
      ex_ff    <= ex_in;
   end

   assign done           = (state_ff == S_DONE);
   assign res.speed      = speed_ff;
   assign res.smooth     = sm_ff;
   assign res.peak       = pk_ff;
   assign res.expression = ex_ff;

   a_peak_covers_speed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (pk_ff >= speed_ff))
      else $error("peak below speed at end of item");

   a_expression_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (ex_ff <= Q16_ONE))
      else $error("expression above one");

   a_start_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> (state_ff == S_IDLE))
      else $error("start while the hand datapath is busy");

   a_take_releases: assert property (@(posedge clock) disable iff (reset)
      (done && cmd.take) |=> (state_ff == S_IDLE))
      else $error("hand datapath did not return to idle after its result was taken");

endmodule

/* tb/tb_hand_motion_expression_tracker.sv */
// Self-checking testbench for the hand motion expression tracker.
// Holds its own per-hand tracking predictor and drives frames with random gaps and stalls.
// Depends on hmet_pkg, hmet_req_if, hmet_rsp_if and hand_motion_expression_tracker.
module tb_hand_motion_expression_tracker;
   import hmet_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Random part of the stimulus: number of items and the number of coefficient settings
   // it is split into.
   localparam int RANDOM_FRAMES = 1930;
   localparam int PHASES        = 10;
   // Extra wait after the drain, to catch any result beyond the predicted ones.
   localparam int SETTLE_CYCLES = 200;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int REPORT_LIMIT  = 10;

   // Register indexes past the map; writes there must leave every coefficient alone.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_FIRST = 3'd5;

   localparam longint SPEED_CEIL = 64'hFFFFFF;
   localparam longint UNITY      = 65536;
   localparam longint HALF_LSB   = 32768;

   // How one hand moves during a gesture of several items.
   typedef enum logic [2:0] {
      MOTION_STILL,
      MOTION_SLOW,
      MOTION_FAST,
      MOTION_FULL,
      MOTION_EXTREME
   } motion_type;

   // Behavior of the result receiver during one stretch of cycles.
   typedef enum logic [1:0] {
      RX_OPEN,
      RX_CHOPPY,
      RX_HELD
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   hmet_req_if req_chan();
   hmet_rsp_if rsp_chan();

   hand_motion_expression_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Predictor copy of the coefficient registers, as last written.
   logic [SCALE_W-1:0] scale_reg  = RST_SPEED_SCALE;
   logic [COEF_W-1:0]  gain_reg   = RST_SMOOTH_GAIN;
   logic [COEF_W-1:0]  decay_reg  = RST_PEAK_DECAY;
   logic [COEF_W-1:0]  bspeed_reg = RST_BLEND_SPEED;
   logic [COEF_W-1:0]  bpeak_reg  = RST_BLEND_PEAK;

   // Predictor copy of the per-hand state; index 0 is the left hand, 1 the right.
   // Entry 0 of the magnitude window is the newest one.
   logic [MAG_W-1:0] mag_window [2][WINDOW_SIZE];
   longint           mag_sum    [2];
   longint           smooth_speed [2];
   longint           peak_hold  [2];

   // Results predicted for accepted items, oldest first.
   rsp_type pending_results [$];

   int fault_count  = 0;
   int result_count = 0;
   int burst_left   = 0;
   int rx_left      = 0;
   rx_mode_type rx_mode = RX_OPEN;

   task automatic report_fault(input string what);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) $display("%s", what);
   endtask

   // Floor of the square root, found one result bit at a time from the top.
   function automatic longint root_floor(input longint v);
      longint r;
      longint t;
      int b;
      r = 0;
      for (b = MAG_W - 1; b >= 0; b--) begin
         t = r | (longint'(1) << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   // A Q1.16 weight above one acts as exactly one.
   function automatic longint limit_to_one(input logic [COEF_W-1:0] c);
      return (longint'(c) > UNITY) ? UNITY : longint'(c);
   endfunction

   // Advances the state of one hand by one frame and returns what the block should report.
   function automatic hand_res_type track_hand(input int h,
                                               input logic signed [VEL_W-1:0] vx,
                                               input logic signed [VEL_W-1:0] vy,
                                               input logic signed [VEL_W-1:0] vz);
      longint sq, spd, g, d, bs, bp, diff, nsm, pk, blend, ex;
      logic [MAG_W-1:0] mag;
      hand_res_type r;
      int i;
      sq = longint'(vx) * longint'(vx) + longint'(vy) * longint'(vy)
         + longint'(vz) * longint'(vz);
      mag = MAG_W'(root_floor(sq));

      // The oldest magnitude leaves the running sum as the new one enters.
      mag_sum[h] = mag_sum[h] - longint'(mag_window[h][WINDOW_SIZE-1]) + longint'(mag);
      for (i = WINDOW_SIZE - 1; i > 0; i--) mag_window[h][i] = mag_window[h][i-1];
      mag_window[h][0] = mag;

      spd = (mag_sum[h] * longint'(scale_reg)) / (WINDOW_SIZE * 256);
      if (spd > SPEED_CEIL) spd = SPEED_CEIL;

      // Smoother step rounds half up, so the arithmetic shift gives the floor.
      g = limit_to_one(gain_reg);
      diff = spd - smooth_speed[h];
      nsm = smooth_speed[h] + ((diff * g + HALF_LSB) >>> 16);
      if (nsm < 0) nsm = 0;
      if (nsm > SPEED_CEIL) nsm = SPEED_CEIL;
      smooth_speed[h] = nsm;

      d = limit_to_one(decay_reg);
      pk = (peak_hold[h] * d + HALF_LSB) >>> 16;
      if (pk > SPEED_CEIL) pk = SPEED_CEIL;
      if (spd > pk) pk = spd;
      peak_hold[h] = pk;

      bs = limit_to_one(bspeed_reg);
      bp = limit_to_one(bpeak_reg);
      blend = (bs * spd + (UNITY - bs) * nsm + HALF_LSB) >>> 16;
      ex = (bp * blend + (UNITY - bp) * pk + HALF_LSB) >>> 16;
      if (ex > UNITY) ex = UNITY;

      r.speed      = SPD_W'(spd);
      r.smooth     = SPD_W'(nsm);
      r.peak       = SPD_W'(pk);
      r.expression = COEF_W'(ex);
      return r;
   endfunction

   function automatic rsp_type predict_frame(input req_type f);
      hand_res_type lh, rh;
      rsp_type r;
      lh = track_hand(0, f.left_vel_x, f.left_vel_y, f.left_vel_z);
      rh = track_hand(1, f.right_vel_x, f.right_vel_y, f.right_vel_z);
      r.left_speed       = lh.speed;
      r.left_smooth      = lh.smooth;
      r.left_peak        = lh.peak;
      r.left_expression  = lh.expression;
      r.right_speed      = rh.speed;
      r.right_smooth     = rh.smooth;
      r.right_peak       = rh.peak;
      r.right_expression = rh.expression;
      return r;
   endfunction

   function automatic req_type frame_of(input int lx, input int ly, input int lz,
                                        input int rx, input int ry, input int rz);
      req_type f;
      f.left_vel_x  = VEL_W'(lx);
      f.left_vel_y  = VEL_W'(ly);
      f.left_vel_z  = VEL_W'(lz);
      f.right_vel_x = VEL_W'(rx);
      f.right_vel_y = VEL_W'(ry);
      f.right_vel_z = VEL_W'(rz);
      return f;
   endfunction

   // Sends one item and records its predicted result once the block takes it. Items go
   // out in bursts; at the start of a new burst the channel idles for a random gap, so the
   // next item lands on a different point of the block's schedule.
   task automatic send_frame(input req_type f);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 150)) @(posedge clock);
      end
      burst_left--;
      req_chan.valid   <= 1'b1;
      req_chan.payload <= f;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_results.insert(pending_results.size(), predict_frame(f));
   endtask

   // One register write; the caller lowers the write enable after its last write.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_SPEED_SCALE: scale_reg  = data[SCALE_W-1:0];
         CSR_SMOOTH_GAIN: gain_reg   = data[COEF_W-1:0];
         CSR_PEAK_DECAY:  decay_reg  = data[COEF_W-1:0];
         CSR_BLEND_SPEED: bspeed_reg = data[COEF_W-1:0];
         CSR_BLEND_PEAK:  bpeak_reg  = data[COEF_W-1:0];
         default: ;
      endcase
   endtask

   // Waits until the block has returned every result, then writes all five registers
   // and one unmapped index with random data.
   task automatic load_config(input logic [CSR_DATA_W-1:0] scale,
                              input logic [CSR_DATA_W-1:0] gain,
                              input logic [CSR_DATA_W-1:0] decay,
                              input logic [CSR_DATA_W-1:0] bspeed,
                              input logic [CSR_DATA_W-1:0] bpeak);
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      @(posedge clock);
      csr_write(CSR_SPEED_SCALE, scale);
      csr_write(CSR_SMOOTH_GAIN, gain);
      csr_write(CSR_PEAK_DECAY, decay);
      csr_write(CSR_BLEND_SPEED, bspeed);
      csr_write(CSR_BLEND_PEAK, bpeak);
      csr_write(CSR_UNMAPPED_FIRST + CSR_IDX_W'($urandom_range(0, 2)),
                CSR_DATA_W'($urandom()));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Picks a weight setting: mostly in range, sometimes an edge or a value above one.
   // Wide values also exercise the write data bits past the 17-bit registers.
   function automatic logic [CSR_DATA_W-1:0] pick_weight(input logic [COEF_W-1:0] dflt);
      case ($urandom_range(0, 6))
         0: return CSR_DATA_W'(dflt);
         1: return '0;
         2: return CSR_DATA_W'(UNITY);
         3: return CSR_DATA_W'($urandom_range(65537, 24'hFFFFFF));
         default: return CSR_DATA_W'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic [VEL_W-1:0] random_velocity(input motion_type m);
      case (m)
         MOTION_STILL:   return ($urandom_range(0, 3) == 0)
                                ? VEL_W'(int'($urandom_range(0, 6)) - 3) : '0;
         MOTION_SLOW:    return VEL_W'(int'($urandom_range(0, 600)) - 300);
         MOTION_FAST:    return VEL_W'(int'($urandom_range(0, 16000)) - 8000);
         MOTION_EXTREME: begin
            case ($urandom_range(0, 3))
               0: return VEL_W'(-32768);
               1: return VEL_W'(32767);
               2: return VEL_W'(-32767);
               default: return '0;
            endcase
         end
         default:        return VEL_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Reset coefficients: zero motion, full-scale vectors of both signs, single axes,
   // exact roots, and a few still frames so the peak has to decay.
   task automatic test_directed_frames();
      send_frame(frame_of(0, 0, 0, 0, 0, 0));
      send_frame(frame_of(32767, 32767, 32767, -32768, -32768, -32768));
      send_frame(frame_of(-32768, -32768, -32768, 32767, 32767, 32767));
      send_frame(frame_of(-32768, 0, 0, 0, 32767, 0));
      send_frame(frame_of(0, -32768, 0, 0, 0, 32767));
      send_frame(frame_of(0, 0, -32768, -1, -1, -1));
      send_frame(frame_of(1, 0, 0, 0, 1, 0));
      send_frame(frame_of(3, 4, 0, 0, -3, -4));
      send_frame(frame_of(-1, 2, -2, 1000, -2000, 2000));
      repeat (3) send_frame(frame_of(0, 0, 0, 0, 0, 0));
   endtask

   // Largest speed factor so the speed and peak saturate, with weights written at or above one
   // (including values wider than the 17-bit registers).
   task automatic test_coefficient_saturation();
      load_config(24'hFFFFFF, 24'hFFFFFF, 24'h010001, 24'h01FFFF, 24'h010000);
      repeat (3) send_frame(frame_of(-32768, -32768, -32768, 32767, -32768, 32767));
      repeat (2) send_frame(frame_of(0, 0, 0, 0, 0, 0));
   endtask

   // Every coefficient at zero: speed stays zero, nothing smooths and the peak drops at once.
   task automatic test_zero_coefficients();
      load_config('0, '0, '0, '0, '0);
      send_frame(frame_of(32767, -32768, 12345, -20000, 5, 30000));
      send_frame(frame_of(0, 0, 0, 0, 0, 0));
   endtask

   // Random gestures under random coefficient settings. Each gesture keeps a motion style
   // per hand for a run of items so the window, smoother and peak build up and fall off.
   task automatic test_random_frames();
      int sent;
      int phase;
      int phase_end;
      int gesture_len;
      int i;
      logic [CSR_DATA_W-1:0] scale;
      motion_type lstyle, rstyle;
      req_type f;
      sent = 0;
      for (phase = 0; phase < PHASES; phase++) begin
         case ($urandom_range(0, 4))
            0: scale = CSR_DATA_W'(RST_SPEED_SCALE);
            1: scale = '0;
            2: scale = 24'hFFFFFF;
            3: scale = CSR_DATA_W'($urandom_range(0, 20000));
            default: scale = CSR_DATA_W'($urandom_range(0, 24'hFFFFFF));
         endcase
         load_config(scale, pick_weight(RST_SMOOTH_GAIN), pick_weight(RST_PEAK_DECAY),
                     pick_weight(RST_BLEND_SPEED), pick_weight(RST_BLEND_PEAK));
         phase_end = (phase + 1) * RANDOM_FRAMES / PHASES;
         while (sent < phase_end) begin
            gesture_len = $urandom_range(1, 30);
            lstyle = motion_type'($urandom_range(0, 4));
            rstyle = motion_type'($urandom_range(0, 4));
            for (i = 0; i < gesture_len && sent < phase_end; i++) begin
               f.left_vel_x  = random_velocity(lstyle);
               f.left_vel_y  = random_velocity(lstyle);
               f.left_vel_z  = random_velocity(lstyle);
               f.right_vel_x = random_velocity(rstyle);
               f.right_vel_y = random_velocity(rstyle);
               f.right_vel_z = random_velocity(rstyle);
               send_frame(f);
               sent++;
            end
         end
      end
   endtask

   // The receiver switches between stretches of always ready, random ready and long holds.
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 2));
         rx_left <= $urandom_range(1, 300);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_mode)
         RX_OPEN:   rsp_chan.ready <= 1'b1;
         RX_CHOPPY: rsp_chan.ready <= 1'($urandom_range(0, 1));
         default:   rsp_chan.ready <= 1'b0;
      endcase
   end

   task automatic check_field(input string name, input logic [SPD_W-1:0] want,
                              input logic [SPD_W-1:0] got);
      if (got !== want)
         report_fault($sformatf("result %0d %s: expected %h, got %h",
                                result_count, name, want, got));
   endtask

   // Every result the block hands over is compared with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         if (pending_results.size() == 0) begin
            report_fault($sformatf("result %0d arrived with no item waiting for it",
                                   result_count));
         end else begin
            want = pending_results.pop_front();
            check_field("left_speed", want.left_speed, got.left_speed);
            check_field("left_smooth", want.left_smooth, got.left_smooth);
            check_field("left_peak", want.left_peak, got.left_peak);
            check_field("left_expression", SPD_W'(want.left_expression),
                        SPD_W'(got.left_expression));
            check_field("right_speed", want.right_speed, got.right_speed);
            check_field("right_smooth", want.right_smooth, got.right_smooth);
            check_field("right_peak", want.right_peak, got.right_peak);
            check_field("right_expression", SPD_W'(want.right_expression),
                        SPD_W'(got.right_expression));
         end
         result_count++;
      end
   end

   initial begin
      int h;
      int i;
      int waited;
      for (h = 0; h < 2; h++) begin
         for (i = 0; i < WINDOW_SIZE; i++) mag_window[h][i] = '0;
         mag_sum[h]      = 0;
         smooth_speed[h] = 0;
         peak_hold[h]    = 0;
      end
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      csr_we           <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_frames();
      test_coefficient_saturation();
      test_zero_coefficients();
      test_random_frames();

      // Let the last results come back, then watch a while longer for anything extra.
      req_chan.valid <= 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_fault($sformatf("%0d predicted results never arrived",
                                pending_results.size()));

      if (fault_count == 0) begin
         $display("tb_hand_motion_expression_tracker: clean");
      end else begin
         $display("tb_hand_motion_expression_tracker: errors");
      end
      $finish;
   end

   // A correct run takes about 6 ms, and under 25 ms even if every item met the longest
   // gap and the longest hold.
   initial begin
      #100ms;
      $display("tb_hand_motion_expression_tracker: errors");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/hmet_pkg.sv
hw/rtl/hmet_req_if.sv
hw/rtl/hmet_rsp_if.sv
hw/rtl/hmet_hand.sv
hw/rtl/hand_motion_expression_tracker.sv
tb/tb_hand_motion_expression_tracker.sv
